// ----- sv/nsf_pkg.sv -----
// Package for the NMEA sentence framer: widths, phase and event codes, hex decode.
package nsf_pkg;

  localparam int unsigned MaxFieldsDef = 32;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned FieldIdxW = 5;
  localparam int unsigned EventW    = 3;
  localparam int unsigned NibbleW   = 4;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 32;

  typedef enum logic [1:0] {
    PhIdle,
    PhBody,
    PhHexHi,
    PhHexLo
  } phase_e;

  typedef enum logic [EventW-1:0] {
    EvIgnored,
    EvData,
    EvSep,
    EvStart,
    EvDigit,
    EvEndOk,
    EvEndMismatch,
    EvEndBadHex
  } event_e;

  localparam logic [ByteW-1:0] ChDollar = 8'h24;
  localparam logic [ByteW-1:0] ChStar   = 8'h2A;
  localparam logic [ByteW-1:0] ChComma  = 8'h2C;

  // {is_hex, value}; value is zero for a non-hex byte
  function automatic logic [NibbleW:0] hex_decode(input logic [ByteW-1:0] c);
    logic [NibbleW:0] r;
    logic [ByteW-1:0] t;
    r = '0;
    t = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
      r = {1'b1, t[NibbleW-1:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
      r = {1'b1, t[NibbleW-1:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
      r = {1'b1, t[NibbleW-1:0]};
    end
    return r;
  endfunction

endpackage

// ----- sv/nsf_step.sv -----
// Per-beat framing logic: next sentence state and the tagged result for one byte.
module nsf_step
  import nsf_pkg::*;
#(
  parameter int unsigned MaxFields = MaxFieldsDef,
  localparam int unsigned FcW = (MaxFields > 2) ? $clog2(MaxFields) : 1
) (
  input  logic [ByteW-1:0]   byte_i,
  input  phase_e             phase_i,
  input  logic [ByteW-1:0]   xor_i,
  input  logic [FcW-1:0]     fc_i,
  input  logic [NibbleW-1:0] nib_i,
  input  logic               fault_i,
  output phase_e             phase_o,
  output logic [ByteW-1:0]   xor_o,
  output logic [FcW-1:0]     fc_o,
  output logic [NibbleW-1:0] nib_o,
  output logic               fault_o,
  output event_e             event_o,
  output logic [ByteW-1:0]   rx_o
);

  localparam logic [FcW-1:0] FcLast = FcW'(MaxFields - 1);

  logic [NibbleW:0] hex;
  logic             sep_ok;

  assign hex    = hex_decode(byte_i);
  assign sep_ok = (byte_i == ChComma) && (fc_i < FcLast);

  // next state
  always_comb begin
    phase_o = phase_i;
    xor_o   = xor_i;
    fc_o    = fc_i;
    nib_o   = nib_i;
    fault_o = fault_i;
    if (byte_i == ChDollar) begin
      phase_o = PhBody;
      xor_o   = '0;
      fc_o    = '0;
      nib_o   = '0;
      fault_o = 1'b0;
    end else begin
      unique case (phase_i)
        PhBody: begin
          if (byte_i == ChStar) begin
            phase_o = PhHexHi;
          end else begin
            xor_o = xor_i ^ byte_i;
            if (sep_ok) fc_o = fc_i + FcW'(1);
          end
        end
        PhHexHi: begin
          fault_o = ~hex[NibbleW];
          nib_o   = hex[NibbleW-1:0];
          phase_o = PhHexLo;
        end
        PhHexLo: phase_o = PhIdle;
        default: phase_o = phase_i;
      endcase
    end
  end

  // result
  always_comb begin
    event_o = EvIgnored;
    rx_o    = '0;
    if (byte_i == ChDollar) begin
      event_o = EvStart;
    end else begin
      unique case (phase_i)
        PhBody: begin
          if (byte_i == ChStar || sep_ok) event_o = EvSep;
          else                           event_o = EvData;
        end
        PhHexHi: event_o = EvDigit;
        PhHexLo: begin
          rx_o = {nib_i, hex[NibbleW-1:0]};
          if (!hex[NibbleW] || fault_i) event_o = EvEndBadHex;
          else if (rx_o == xor_i)       event_o = EvEndOk;
          else                          event_o = EvEndMismatch;
        end
        default: event_o = EvIgnored;
      endcase
    end
  end

endmodule

// ----- sv/nmea_sentence_framer_core.sv -----
// NMEA 0183 sentence framer top level: input beat register, framing step, result register.
// Path: an accepted input beat is held in the input beat register, then its result is held in the result register.
// Throughput: one byte per cycle while the sink does not stall; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset: rst_ni clears both valid flags and the sentence state (idle phase).
module nmea_sentence_framer_core
  import nsf_pkg::*;
#(
  parameter int unsigned MaxFields = MaxFieldsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [7:0] out_byte, [12:8] field_index, [15:13] event_res,
  // [23:16] calc_checksum, [31:24] rx_checksum
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned FcW = (MaxFields > 2) ? $clog2(MaxFields) : 1;

  logic               in_valid_q;
  logic [ByteW-1:0]   in_byte_q;
  logic               out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic               advance;

  phase_e             phase_q, phase_d;
  logic [ByteW-1:0]   xor_q, xor_d;
  logic [FcW-1:0]     fc_q, fc_d;
  logic [NibbleW-1:0] nib_q, nib_d;
  logic               fault_q, fault_d;
  event_e             event_d;
  logic [ByteW-1:0]   rx_d;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  nsf_step #(
    .MaxFields(MaxFields)
  ) u_step (
    .byte_i (in_byte_q),
    .phase_i(phase_q),
    .xor_i  (xor_q),
    .fc_i   (fc_q),
    .nib_i  (nib_q),
    .fault_i(fault_q),
    .phase_o(phase_d),
    .xor_o  (xor_d),
    .fc_o   (fc_d),
    .nib_o  (nib_d),
    .fault_o(fault_d),
    .event_o(event_d),
    .rx_o   (rx_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PhIdle;
      xor_q       <= '0;
      fc_q        <= '0;
      nib_q       <= '0;
      fault_q     <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (advance) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        xor_q       <= xor_d;
        fc_q        <= fc_d;
        nib_q       <= nib_d;
        fault_q     <= fault_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) in_byte_q <= s_axis_tdata_i;
    if (advance) begin
      out_data_q <= {rx_d, xor_d, event_d, FieldIdxW'(fc_d), in_byte_q};
    end
  end

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && event_d == EvStart |=> xor_q == '0 && fc_q == '0 && phase_q == PhBody)
    else $error("start beat did not clear sentence state");

  a_end_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (event_d == EvEndOk || event_d == EvEndMismatch || event_d == EvEndBadHex)
    |=> phase_q == PhIdle)
    else $error("end of sentence did not return to idle");

  a_rx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !(m_axis_tdata_o[15:13] == EvEndOk || m_axis_tdata_o[15:13] == EvEndMismatch
    || m_axis_tdata_o[15:13] == EvEndBadHex) |-> m_axis_tdata_o[31:24] == '0)
    else $error("received checksum nonzero on a non-end beat");

  a_fc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= FcW'(MaxFields - 1))
    else $error("field index past last field");

endmodule

// ----- bench/nsf_result_checker.sv -----
// Checker for the NMEA sentence framer: predicts each result beat and compares it.
module nsf_result_checker
  import nsf_pkg::*;
#(
  parameter int unsigned MaxFields = MaxFieldsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [OutDataW-1:0] out_data_i,
  output int                  mismatch_cnt_o,
  output int                  pending_o
);

  // lowest bits first: echo, field, ev, calc, rx_sum
  typedef struct packed {
    logic [ByteW-1:0]     rx_sum;
    logic [ByteW-1:0]     calc;
    event_e               ev;
    logic [FieldIdxW-1:0] field;
    logic [ByteW-1:0]     echo;
  } frame_beat_t;

  phase_e           sent_phase;
  logic [ByteW-1:0] sum_acc;
  int unsigned      field_cnt;
  logic [3:0]       hi_digit;
  logic             hi_bad;
  frame_beat_t      expected_beats[$];
  int               errs;

  // {valid, value}
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h41 + 8'd10;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h61 + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'b0;
  endfunction

  task automatic frame_step(input logic [7:0] c, output frame_beat_t r);
    logic [4:0] dig;
    r = '0;
    r.echo = c;
    r.ev = EvIgnored;
    if (c == ChDollar) begin
      sent_phase = PhBody;
      sum_acc = '0;
      field_cnt = 0;
      hi_digit = '0;
      hi_bad = 1'b0;
      r.ev = EvStart;
    end else begin
      case (sent_phase)
        PhBody: begin
          if (c == ChStar) begin
            sent_phase = PhHexHi;
            r.ev = EvSep;
          end else if (c == ChComma && field_cnt < MaxFields - 1) begin
            sum_acc ^= c;
            field_cnt++;
            r.ev = EvSep;
          end else begin
            sum_acc ^= c;
            r.ev = EvData;
          end
        end
        PhHexHi: begin
          dig = nibble_of(c);
          hi_bad = !dig[4];
          hi_digit = dig[3:0];
          sent_phase = PhHexLo;
          r.ev = EvDigit;
        end
        PhHexLo: begin
          dig = nibble_of(c);
          r.rx_sum = {hi_digit, dig[3:0]};
          if (!dig[4] || hi_bad) r.ev = EvEndBadHex;
          else if (r.rx_sum == sum_acc) r.ev = EvEndOk;
          else r.ev = EvEndMismatch;
          sent_phase = PhIdle;
        end
        default: ;
      endcase
    end
    r.field = field_cnt[FieldIdxW-1:0];
    r.calc = sum_acc;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_beat_t want;
    frame_beat_t got;
    if (!rst_ni) begin
      sent_phase = PhIdle;
      sum_acc = '0;
      field_cnt = 0;
      hi_digit = '0;
      hi_bad = 1'b0;
      expected_beats.delete();
      errs = 0;
      mismatch_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = frame_beat_t'(out_data_i);
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat %08h", out_data_i);
          errs++;
        end else begin
          want = expected_beats.pop_front();
          if (got.echo != want.echo) begin
            $error("out_byte: expected %0h, got %0h", want.echo, got.echo);
            errs++;
          end
          if (got.field != want.field) begin
            $error("field_index: expected %0d, got %0d", want.field, got.field);
            errs++;
          end
          if (got.ev != want.ev) begin
            $error("event_res: expected %0d, got %0d", want.ev, got.ev);
            errs++;
          end
          if (got.calc != want.calc) begin
            $error("calc_checksum: expected %0h, got %0h", want.calc, got.calc);
            errs++;
          end
          if (got.rx_sum != want.rx_sum) begin
            $error("rx_checksum: expected %0h, got %0h", want.rx_sum, got.rx_sum);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        frame_step(in_data_i, want);
        expected_beats.push_back(want);
      end
      mismatch_cnt_o <= errs;
      pending_o <= expected_beats.size();
    end
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the NMEA sentence framer bench: clock, reset, byte stimulus, result sink and verdict.
module testbench;
  import nsf_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic [InDataW-1:0]  s_data = '0;
  logic                s_ready;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;
  int                  mismatches;
  int                  pending;
  logic                quiet = 1'b0;
  logic [7:0]          stim_q[$];

  always #1 clk_i = ~clk_i;

  nmea_sentence_framer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  nsf_result_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_valid),
    .in_ready_i     (s_ready),
    .in_data_i      (s_data),
    .out_valid_i    (m_valid),
    .out_ready_i    (m_ready),
    .out_data_i     (m_data),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending)
  );

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = 8'h30 + 8'(n);
    else if ($urandom_range(0, 1) == 0) c = 8'h41 + 8'(n - 4'd10);
    else c = 8'h61 + 8'(n - 4'd10);
    return c;
  endfunction

  function automatic logic [7:0] junk_hex();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66) || c == ChDollar);
    return c;
  endfunction

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 7) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(8'h20, 8'h7E));
    end while (c == ChDollar || c == ChStar);
    return c;
  endfunction

  task automatic push_noise();
    logic [7:0] c;
    repeat ($urandom_range(0, 2)) begin
      do c = 8'($urandom_range(0, 255)); while (c == ChDollar);
      stim_q.push_back(c);
    end
  endtask

  task automatic push_sentence();
    int         nf;
    int         mode;
    int         len;
    logic [7:0] sum;
    logic [7:0] c;
    logic [7:0] rx;
    nf = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 8);
    mode = $urandom_range(0, 15);
    sum = '0;
    stim_q.push_back(ChDollar);
    repeat ($urandom_range(1, 5)) begin
      c = 8'h41 + 8'($urandom_range(0, 25));
      stim_q.push_back(c);
      sum ^= c;
    end
    for (int f = 0; f < nf; f++) begin
      stim_q.push_back(ChComma);
      sum ^= ChComma;
      len = (nf > 20) ? $urandom_range(0, 1) : $urandom_range(0, 6);
      repeat (len) begin
        c = body_char();
        stim_q.push_back(c);
        sum ^= c;
      end
    end
    // truncated sentence: the next '$' restarts
    if (mode == 15) return;
    stim_q.push_back(ChStar);
    rx = (mode == 10 || mode == 11) ? sum ^ 8'($urandom_range(1, 255)) : sum;
    stim_q.push_back((mode == 12 || mode == 14) ? junk_hex() : hex_char(rx[7:4]));
    stim_q.push_back((mode == 13 || mode == 14) ? junk_hex() : hex_char(rx[3:0]));
  endtask

  task automatic send_beat(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= b;
    do @(posedge clk_i); while (!s_ready);
  endtask

  // result sink: random stalls plus two long hold-offs that back up the block
  initial begin
    int cyc;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc == 200 || cyc == 1500) begin
        m_ready <= 1'b0;
        repeat (60) @(posedge clk_i);
        m_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        m_ready <= 1'b1;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  initial begin
    // idle bytes, restarts in every phase, bad high/low digits, ok and mismatch ends
    stim_q = '{8'h00, 8'hFF, ChStar, ChComma,
               ChDollar, "G", 8'h80, 8'h01, ChComma, ChDollar, "A", ChStar,
               ChDollar, ChStar, "z", "5",
               ChDollar, ChStar, "0", "g",
               ChDollar, "a", ChStar, "6", "1",
               ChDollar, ChStar, "0", ChDollar, ChStar, "F", "f"};
    while (stim_q.size() < 1230) begin
      push_noise();
      push_sentence();
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (stim_q[i]) begin
      quiet = (i >= stim_q.size() - 150);
      send_beat(stim_q[i]);
    end
    s_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
sv/nsf_pkg.sv
sv/nsf_step.sv
sv/nmea_sentence_framer_core.sv
bench/nsf_result_checker.sv
bench/testbench.sv
